[hw/rtl/magnetometer_iron_calibration_unit_defines.svh]
// ----------------------------------------------------------------------------
// magnetometer iron calibration assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef MAGNETOMETER_IRON_CALIBRATION_UNIT_DEFINES_SVH
`define MAGNETOMETER_IRON_CALIBRATION_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MIC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mic assertion failed");

// next-cycle implication, disabled while reset is low
`define MIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mic assertion failed");

`endif

[hw/rtl/mic_pkg.sv]
// ----------------------------------------------------------------------------
// mic_pkg
// shared constants, codes, types and helpers of the iron calibration unit
// ----------------------------------------------------------------------------
package mic_pkg;

    // field widths
    localparam int SAMPLE_BITS          = 16;
    localparam int OFS_W                = 17;
    localparam int SCL_W                = 16;
    localparam int OUT_W                = 24;
    localparam int SCALE_FRACTION_BITS  = 12;
    localparam int OUTPUT_FRACTION_BITS = 4;
    localparam int CAL_SHIFT            = SCALE_FRACTION_BITS + 1 - OUTPUT_FRACTION_BITS;

    // exponential filter, alpha 154/1024
    localparam int ALPHA_NUM   = 154;
    localparam int ALPHA_SHIFT = 10;

    // min/max seed
    localparam int SEED_LIMIT = 32000;

    // shared multiplier operands and product
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // divider sizes
    localparam int DIV_N_W   = 32;
    localparam int DIV_D_W   = 19;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_START  = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_APPLY  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_OFS_X = 3'd0,
        REG_OFS_Y = 3'd1,
        REG_OFS_Z = 3'd2,
        REG_SCL_X = 3'd3,
        REG_SCL_Y = 3'd4,
        REG_SCL_Z = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } t_div_rsp;

    // clamp a wide signed value to the output range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'((2 ** (OUT_W - 1)) - 1);
        lo = -hi - PROD_W'(1);
        if (v > hi) begin
            return OUT_W'(hi);
        end else if (v < lo) begin
            return OUT_W'(lo);
        end
        return OUT_W'(v);
    endfunction

endpackage

[hw/rtl/mic_if.sv]
// ----------------------------------------------------------------------------
// mic_if
// request channels of the iron calibration unit: sample in, field out
// ----------------------------------------------------------------------------
interface mic_in_if import mic_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic                          data_ready;
    logic signed [SAMPLE_BITS-1:0] raw_x;
    logic signed [SAMPLE_BITS-1:0] raw_y;
    logic signed [SAMPLE_BITS-1:0] raw_z;

    modport source (output valid, command, data_ready, raw_x, raw_y, raw_z, input ready);
    modport sink   (input valid, command, data_ready, raw_x, raw_y, raw_z, output ready);
endinterface

interface mic_out_if import mic_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] field_x;
    logic signed [OUT_W-1:0] field_y;
    logic signed [OUT_W-1:0] field_z;
    logic                    calibrating;
    logic                    scale_fault;
    logic                    sample_used;

    modport source (output valid, field_x, field_y, field_z, calibrating, scale_fault,
                    sample_used, input ready);
    modport sink   (input valid, field_x, field_y, field_z, calibrating, scale_fault,
                    sample_used, output ready);
endinterface

[hw/rtl/magnetometer_iron_calibration_unit.sv]
// ----------------------------------------------------------------------------
// magnetometer_iron_calibration_unit
// hard/soft-iron calibration and smoothing of three-axis magnetometer samples
// ----------------------------------------------------------------------------
// i_in carries one request: a command and a raw sample (sensor X/Y swapped).
// Each request gives exactly one result on o_out: the filtered field of all
// three axes with 4 fraction bits, the calibrating and fault flags and
// whether the sample was taken. Presets are to be written on the i_cfg port
// while the unit is idle; the unit itself does not enforce this.
// Steps from accept to result valid:
//   start, apply, sample while calibrating or not ready: straight to the result
//   calibrated sample: multiply and round per axis, then filter steps A, B and
//     round per axis (none when the filter loads directly)
//   finish: per axis, a setup step and the bit-serial divider unless skipped
// One request is in work at a time; i_in.ready is high only when idle, so the
// next request is accepted only after the last one has left. A single output
// register holds the result; while the receiver stalls, the next request may
// be accepted and processed, but it waits at the end until the register is
// free.
// Synchronous reset clears the calibration state to its defaults (seeds,
// zero offset, unit scale, zero filter) and leaves no result pending.
// ----------------------------------------------------------------------------
module magnetometer_iron_calibration_unit import mic_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    mic_in_if.sink                i_in,
    mic_out_if.source             o_out
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_CAL_MUL  = 9'b000000010,
        S_CAL_RND  = 9'b000000100,
        S_FLT_A    = 9'b000001000,
        S_FLT_B    = 9'b000010000,
        S_FLT_RND  = 9'b000100000,
        S_DIV_SET  = 9'b001000000,
        S_DIV_WAIT = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state r_state;
    logic [1:0] r_ax;

    // presets
    logic signed [OFS_W-1:0] r_pre_ofs [3];
    logic        [SCL_W-1:0] r_pre_scl [3];

    // calibration state
    logic signed [SAMPLE_BITS-1:0] r_min  [3];
    logic signed [SAMPLE_BITS-1:0] r_max  [3];
    logic signed [OFS_W-1:0]       r_ofs  [3];
    logic        [SCL_W-1:0]       r_scl  [3];
    logic signed [OUT_W-1:0]       r_filt [3];
    logic                          r_calib;
    logic                          r_fault;
    logic                          r_fault_acc;

    // working registers
    logic signed [SAMPLE_BITS-1:0] r_smp [3];
    logic signed [OUT_W-1:0]       r_cal [3];
    logic signed [OFS_W-1:0]       r_d   [3];
    logic signed [OFS_W+1:0]       r_sum;
    logic                          r_used;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [PROD_W-1:0]      r_acc;

    // output register
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_field [3];
    logic                    r_out_calib;
    logic                    r_out_fault;
    logic                    r_out_used;

    logic accept;
    logic out_free;
    logic last_ax;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    // rounding of products
    logic signed [PROD_W-1:0] cal_rnd;
    logic signed [OUT_W-1:0]  cal_val;
    logic signed [PROD_W-1:0] flt_rnd;
    logic signed [OUT_W-1:0]  flt_val;

    // finish setup
    logic signed [OFS_W-1:0]   fin_ofs [3];
    logic signed [OFS_W-1:0]   fin_d   [3];
    logic signed [OFS_W+1:0]   fin_sum;
    logic signed [OFS_W-1:0]   cur_d;
    logic        [OFS_W-1:0]   abs_d;
    logic        [OFS_W+1:0]   abs_sum;
    logic        [DIV_D_W-1:0] den3;
    logic                      d_zero;
    logic                      d_skip;
    logic                      n_fault_acc;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;
    logic        [SCL_W-1:0]   div_scl;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign last_ax  = (r_ax == 2'd2);

    // multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_CAL_MUL: begin
                mul_a = {{(MUL_A_W-SAMPLE_BITS-1){r_smp[r_ax][SAMPLE_BITS-1]}}, r_smp[r_ax], 1'b0}
                      - MUL_A_W'(r_ofs[r_ax]);
                mul_b = MUL_B_W'(r_scl[r_ax]);
            end
            S_FLT_A: begin
                mul_a = MUL_A_W'(r_cal[r_ax]);
                mul_b = MUL_B_W'(ALPHA_NUM);
            end
            S_FLT_B: begin
                mul_a = MUL_A_W'(r_filt[r_ax]);
                mul_b = MUL_B_W'((1 << ALPHA_SHIFT) - ALPHA_NUM);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // round half up and saturate
    always_comb begin
        cal_rnd = (r_prod + (PROD_W'(1) <<< (CAL_SHIFT - 1))) >>> CAL_SHIFT;
        cal_val = sat_out(cal_rnd);
        flt_rnd = (r_acc + r_prod + (PROD_W'(1) <<< (ALPHA_SHIFT - 1))) >>> ALPHA_SHIFT;
        flt_val = sat_out(flt_rnd);
    end

    // offsets, ranges and their sum from min/max
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fin_ofs[i] = OFS_W'(r_max[i]) + OFS_W'(r_min[i]);
            fin_d[i]   = OFS_W'(r_max[i]) - OFS_W'(r_min[i]);
        end
        fin_sum = (OFS_W+2)'(fin_d[0]) + (OFS_W+2)'(fin_d[1]) + (OFS_W+2)'(fin_d[2]);
    end

    // divider operands for the current axis
    always_comb begin
        cur_d       = r_d[r_ax];
        abs_d       = cur_d[OFS_W-1] ? OFS_W'(-cur_d) : OFS_W'(cur_d);
        abs_sum     = r_sum[OFS_W+1] ? (OFS_W+2)'(-r_sum) : (OFS_W+2)'(r_sum);
        den3        = DIV_D_W'({abs_d, 1'b0}) + DIV_D_W'(abs_d);
        d_zero      = (cur_d == '0);
        d_skip      = (r_sum == '0) || (r_sum[OFS_W+1] != cur_d[OFS_W-1]);
        n_fault_acc = r_fault_acc | d_zero;

        div_req.start    = (r_state == S_DIV_SET) && !d_zero && !d_skip;
        div_req.dividend = (DIV_N_W'(abs_sum) << (SCALE_FRACTION_BITS + 1)) + DIV_N_W'(den3);
        div_req.divisor  = {den3[DIV_D_W-2:0], 1'b0};

        div_scl = (div_rsp.quotient > DIV_N_W'({SCL_W{1'b1}})) ? {SCL_W{1'b1}}
                                                               : div_rsp.quotient[SCL_W-1:0];
    end

    mic_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // preset registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_pre_ofs[i] <= '0;
                r_pre_scl[i] <= SCL_W'(1 << SCALE_FRACTION_BITS);
            end
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_OFS_X: r_pre_ofs[0] <= i_cfg_wdata[OFS_W-1:0];
                REG_OFS_Y: r_pre_ofs[1] <= i_cfg_wdata[OFS_W-1:0];
                REG_OFS_Z: r_pre_ofs[2] <= i_cfg_wdata[OFS_W-1:0];
                REG_SCL_X: r_pre_scl[0] <= i_cfg_wdata[SCL_W-1:0];
                REG_SCL_Y: r_pre_scl[1] <= i_cfg_wdata[SCL_W-1:0];
                REG_SCL_Z: r_pre_scl[2] <= i_cfg_wdata[SCL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer and calibration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ax        <= '0;
            r_calib     <= 1'b0;
            r_fault     <= 1'b0;
            r_fault_acc <= 1'b0;
            r_used      <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_min[i]  <= SAMPLE_BITS'(SEED_LIMIT);
                r_max[i]  <= SAMPLE_BITS'(-SEED_LIMIT);
                r_ofs[i]  <= '0;
                r_scl[i]  <= SCL_W'(1 << SCALE_FRACTION_BITS);
                r_filt[i] <= '0;
            end
        end else begin
            r_prod <= mul_p;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_smp[0] <= i_in.raw_y;
                        r_smp[1] <= i_in.raw_x;
                        r_smp[2] <= i_in.raw_z;
                        r_ax     <= '0;
                        r_used   <= 1'b0;
                        r_state  <= S_DONE;
                        case (t_cmd'(i_in.command))
                            CMD_START: begin
                                for (int i = 0; i < 3; i++) begin
                                    r_min[i] <= SAMPLE_BITS'(SEED_LIMIT);
                                    r_max[i] <= SAMPLE_BITS'(-SEED_LIMIT);
                                end
                                r_calib <= 1'b1;
                            end
                            CMD_FINISH: begin
                                for (int i = 0; i < 3; i++) begin
                                    r_ofs[i] <= fin_ofs[i];
                                    r_d[i]   <= fin_d[i];
                                end
                                r_sum       <= fin_sum;
                                r_calib     <= 1'b0;
                                r_fault_acc <= 1'b0;
                                r_state     <= S_DIV_SET;
                            end
                            CMD_APPLY: begin
                                for (int i = 0; i < 3; i++) begin
                                    r_ofs[i] <= r_pre_ofs[i];
                                    r_scl[i] <= r_pre_scl[i];
                                end
                            end
                            default: begin
                                if (i_in.data_ready) begin
                                    r_used <= 1'b1;
                                    if (r_calib) begin
                                        // widen min/max, swapped X/Y
                                        if (i_in.raw_y < r_min[0]) r_min[0] <= i_in.raw_y;
                                        if (i_in.raw_y > r_max[0]) r_max[0] <= i_in.raw_y;
                                        if (i_in.raw_x < r_min[1]) r_min[1] <= i_in.raw_x;
                                        if (i_in.raw_x > r_max[1]) r_max[1] <= i_in.raw_x;
                                        if (i_in.raw_z < r_min[2]) r_min[2] <= i_in.raw_z;
                                        if (i_in.raw_z > r_max[2]) r_max[2] <= i_in.raw_z;
                                    end else begin
                                        r_state <= S_CAL_MUL;
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_CAL_MUL: begin
                    r_state <= S_CAL_RND;
                end
                S_CAL_RND: begin
                    r_cal[r_ax] <= cal_val;
                    if (last_ax) begin
                        r_ax <= '0;
                        // filter loads directly while filtered X and Y are zero
                        if (r_filt[0] == '0 && r_filt[1] == '0) begin
                            r_filt[0] <= r_cal[0];
                            r_filt[1] <= r_cal[1];
                            r_filt[2] <= cal_val;
                            r_state   <= S_DONE;
                        end else begin
                            r_state <= S_FLT_A;
                        end
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_CAL_MUL;
                    end
                end
                S_FLT_A: begin
                    r_state <= S_FLT_B;
                end
                S_FLT_B: begin
                    r_acc   <= r_prod;
                    r_state <= S_FLT_RND;
                end
                S_FLT_RND: begin
                    r_filt[r_ax] <= flt_val;
                    if (last_ax) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_FLT_A;
                    end
                end
                S_DIV_SET: begin
                    r_fault_acc <= n_fault_acc;
                    if (d_zero || d_skip) begin
                        r_scl[r_ax] <= d_zero ? {SCL_W{1'b1}} : '0;
                        if (last_ax) begin
                            r_fault <= n_fault_acc;
                            r_state <= S_DONE;
                        end else begin
                            r_ax <= r_ax + 2'd1;
                        end
                    end else begin
                        r_state <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        r_scl[r_ax] <= div_scl;
                        if (last_ax) begin
                            r_fault <= r_fault_acc;
                            r_state <= S_DONE;
                        end else begin
                            r_ax    <= r_ax + 2'd1;
                            r_state <= S_DIV_SET;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            for (int i = 0; i < 3; i++) begin
                r_out_field[i] <= r_filt[i];
            end
            r_out_calib <= r_calib;
            r_out_fault <= r_fault;
            r_out_used  <= r_used;
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.field_x     = r_out_field[0];
    assign o_out.field_y     = r_out_field[1];
    assign o_out.field_z     = r_out_field[2];
    assign o_out.calibrating = r_out_calib;
    assign o_out.scale_fault = r_out_fault;
    assign o_out.sample_used = r_out_used;

endmodule

[hw/rtl/mic_div.sv]
// ----------------------------------------------------------------------------
// mic_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mic_div import mic_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_den;

    logic [DIV_D_W:0]     rem_sh;
    logic                 q_bit;
    logic [DIV_D_W:0]     rem_sub;

    // one trial subtraction
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_N_W-1]};
        q_bit   = (rem_sh >= {1'b0, r_den});
        rem_sub = rem_sh - {1'b0, r_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_N_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

[hw/rtl/mic_chk.sv]
// ----------------------------------------------------------------------------
// mic_chk
// port-level checks of the iron calibration unit, bound to the top level
// ----------------------------------------------------------------------------
`include "magnetometer_iron_calibration_unit_defines.svh"

module mic_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_calibrating,
    input logic i_out_sample_used
);

    // a pending result holds until taken
    `MIC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // one request in work at a time
    `MIC_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // reset leaves the unit idle with nothing pending
    `MIC_ASSERT_NEXT(a_reset_idle, i_clk, 1'b1, !i_rst_n, !i_out_valid && i_in_ready)

    // flags are known whenever a result is shown
    `MIC_ASSERT_IMPLY(a_flags_known, i_clk, i_rst_n, i_out_valid,
        !$isunknown(i_out_calibrating) && !$isunknown(i_out_sample_used))

endmodule

bind magnetometer_iron_calibration_unit mic_chk u_mic_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_calibrating (o_out.calibrating),
    .i_out_sample_used (o_out.sample_used)
);

[test/magnetometer_iron_calibration_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_iron_calibration_unit_tb
// checks filtered field, flags and sample use of the iron calibration unit
// against a cycle-free predictor, with random stalls on both channels
// ----------------------------------------------------------------------------

// expected field results and their check
class field_scoreboard;
    typedef struct {
        logic signed [23:0] fx, fy, fz;
        logic cal, fault, used;
    } t_field;

    t_field pending[$];
    int errors;
    int n_used;
    int n_checked;

    logic signed [16:0] pre_ofs[3];
    logic [15:0]        pre_scl[3];
    int                 amin[3], amax[3];
    logic signed [16:0] ofs[3];
    logic [15:0]        scl[3];
    longint             filt[3];
    bit                 calib, fault;

    function new();
        for (int i = 0; i < 3; i++) begin
            pre_ofs[i] = 0; pre_scl[i] = 16'd4096;
            amin[i] = 32000; amax[i] = -32000;
            ofs[i] = 0; scl[i] = 16'd4096; filt[i] = 0;
        end
        calib = 0; fault = 0;
        errors = 0; n_used = 0; n_checked = 0;
    endfunction

    function void write_preset(int idx, logic [16:0] v);
        if (idx < 3) pre_ofs[idx] = v;
        else if (idx < 6) pre_scl[idx-3] = v[15:0];
    endfunction

    // floor((v + 2^(sh-1)) / 2^sh)
    function longint rnd_shift(longint v, int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function longint sat24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function void note_request(logic [1:0] cmd, bit rdy,
                               logic signed [15:0] rx, ry, rz);
        longint s[3], d[3], cal[3], sum, num, den, q;
        bit used, flt;
        t_field r;
        used = 0;
        case (cmd)
            mic_pkg::CMD_START: begin
                for (int i = 0; i < 3; i++) begin
                    amin[i] = 32000; amax[i] = -32000;
                end
                calib = 1;
            end
            mic_pkg::CMD_FINISH: begin
                calib = 0; flt = 0; sum = 0;
                for (int i = 0; i < 3; i++) begin
                    ofs[i] = amax[i] + amin[i];
                    d[i] = amax[i] - amin[i];
                    sum += d[i];
                end
                for (int i = 0; i < 3; i++) begin
                    if (d[i] == 0) begin
                        scl[i] = 16'hFFFF; flt = 1;
                    end else if (sum == 0 || ((sum < 0) != (d[i] < 0))) begin
                        scl[i] = 0;
                    end else begin
                        num = (sum < 0 ? -sum : sum) << 12;
                        den = 3 * (d[i] < 0 ? -d[i] : d[i]);
                        q = (2 * num + den) / (2 * den);
                        scl[i] = (q > 65535) ? 16'hFFFF : q[15:0];
                    end
                end
                fault = flt;
            end
            mic_pkg::CMD_APPLY: begin
                for (int i = 0; i < 3; i++) begin
                    ofs[i] = pre_ofs[i]; scl[i] = pre_scl[i];
                end
            end
            default: begin
                if (rdy) begin
                    // sensor x and y are swapped
                    s[0] = ry; s[1] = rx; s[2] = rz;
                    used = 1;
                    if (calib) begin
                        for (int i = 0; i < 3; i++) begin
                            if (s[i] < amin[i]) amin[i] = s[i];
                            if (s[i] > amax[i]) amax[i] = s[i];
                        end
                    end else begin
                        for (int i = 0; i < 3; i++)
                            cal[i] = sat24(rnd_shift((2 * s[i] - longint'(ofs[i]))
                                                     * longint'(scl[i]), 9));
                        if (filt[0] == 0 && filt[1] == 0) begin
                            for (int i = 0; i < 3; i++) filt[i] = cal[i];
                        end else begin
                            for (int i = 0; i < 3; i++)
                                filt[i] = sat24(rnd_shift(154 * cal[i] + 870 * filt[i], 10));
                        end
                    end
                end
            end
        endcase
        if (used) n_used++;
        r.fx = filt[0]; r.fy = filt[1]; r.fz = filt[2];
        r.cal = calib; r.fault = fault; r.used = used;
        pending.push_back(r);
    endfunction

    function void check_result(logic signed [23:0] fx, fy, fz, bit c, f, u);
        t_field e;
        n_checked++;
        if (pending.size() == 0) begin
            $error("result with nothing expected");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (fx !== e.fx) begin $error("field_x exp %0d got %0d", e.fx, fx); errors++; end
        if (fy !== e.fy) begin $error("field_y exp %0d got %0d", e.fy, fy); errors++; end
        if (fz !== e.fz) begin $error("field_z exp %0d got %0d", e.fz, fz); errors++; end
        if (c !== e.cal) begin $error("calibrating exp %0d got %0d", e.cal, c); errors++; end
        if (f !== e.fault) begin
            $error("scale_fault exp %0d got %0d", e.fault, f); errors++;
        end
        if (u !== e.used) begin
            $error("sample_used exp %0d got %0d", e.used, u); errors++;
        end
    endfunction
endclass

module magnetometer_iron_calibration_unit_tb;
    import mic_pkg::*;

    localparam longint CYCLE_LIMIT = 4000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    longint cycles;
    bit stim_done;
    bit stall_on;

    mic_in_if  in_ch();
    mic_out_if out_ch();
    field_scoreboard board;

    magnetometer_iron_calibration_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] v);
        @(negedge i_clk);
        i_cfg_wr_en = 1; i_cfg_addr = idx; i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_wr_en = 0;
        board.write_preset(int'(idx), v);
    endtask

    task automatic send_request(t_cmd cmd, bit rdy, logic signed [15:0] rx, ry, rz);
        int g;
        g = stall_on ? gap_len() : 0;
        repeat (g) @(negedge i_clk);
        in_ch.valid = 1; in_ch.command = cmd; in_ch.data_ready = rdy;
        in_ch.raw_x = rx; in_ch.raw_y = ry; in_ch.raw_z = rz;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_request(cmd, rdy, rx, ry, rz);
        @(negedge i_clk);
        in_ch.valid = 0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rnd_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_sample(bit rdy);
        send_request(CMD_SAMPLE, rdy, rnd_sample(), rnd_sample(), rnd_sample());
    endtask

    // a full calibration sequence with random content
    task automatic calib_sequence(int n);
        send_request(CMD_START, 1'($urandom_range(0, 1)),
                     16'($urandom), 16'($urandom), 16'($urandom));
        for (int k = 0; k < n; k++) random_sample($urandom_range(0, 7) != 0);
        send_request(CMD_FINISH, 1'($urandom_range(0, 1)),
                     16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic random_presets(bit extreme);
        for (int i = 0; i < 3; i++)
            write_reg(t_reg_idx'(i), extreme ? ($urandom_range(0, 1) ? 17'h0FFFF : 17'h10000)
                                             : CFG_DATA_W'($urandom_range(0, 2047) - 1024));
        for (int i = 3; i < 6; i++)
            write_reg(t_reg_idx'(i), extreme ? ($urandom_range(0, 1) ? 17'h0FFFF : 17'h00000)
                                             : CFG_DATA_W'($urandom_range(2048, 8192)));
    endtask

    // receiver with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 0;
        else if (!stall_on) out_ch.ready <= 1;
        else out_ch.ready <= ($urandom_range(0, 9) < 6);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.field_x, out_ch.field_y, out_ch.field_z,
                               out_ch.calibrating, out_ch.scale_fault, out_ch.sample_used);
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        board = new();
        cycles = 0; stim_done = 0; stall_on = 0;
        i_rst_n = 0; i_cfg_wr_en = 0; i_cfg_addr = 0; i_cfg_wdata = 0;
        in_ch.valid = 0; in_ch.command = CMD_SAMPLE; in_ch.data_ready = 0;
        in_ch.raw_x = 0; in_ch.raw_y = 0; in_ch.raw_z = 0;
        out_ch.ready = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;

        // directed: defaults, extremes, every command and corner
        send_request(CMD_SAMPLE, 1, 16'sh7FFF, 16'sh8000, 16'sh0000);
        send_request(CMD_SAMPLE, 0, 16'sh1234, 16'sh4321, 16'sh0F0F);
        send_request(CMD_SAMPLE, 1, 16'sh8000, 16'sh7FFF, -16'sd1);
        send_request(CMD_FINISH, 1, 0, 0, 0);            // no samples: negative range
        send_request(CMD_SAMPLE, 1, 16'sd100, 16'sd200, 16'sd300);
        send_request(CMD_START, 1, 16'sd5, 16'sd5, 16'sd5);
        send_request(CMD_SAMPLE, 1, 16'sd10, 16'sd20, 16'sd30);
        send_request(CMD_FINISH, 0, 0, 0, 0);            // zero range on each axis
        send_request(CMD_SAMPLE, 1, 16'sd11, 16'sd21, 16'sd31);
        send_request(CMD_START, 0, 0, 0, 0);
        send_request(CMD_SAMPLE, 1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_request(CMD_SAMPLE, 1, 16'sh8000, 16'sh8000, 16'sh8000);
        send_request(CMD_SAMPLE, 0, 16'sd1, 16'sd1, 16'sd1);
        send_request(CMD_FINISH, 0, 0, 0, 0);
        send_request(CMD_FINISH, 0, 0, 0, 0);            // finish while idle
        send_request(CMD_SAMPLE, 1, 16'sd1000, -16'sd1000, 16'sd0);
        drain();
        for (int i = 0; i < 3; i++) write_reg(t_reg_idx'(i), 17'h0FFFF);
        for (int i = 3; i < 6; i++) write_reg(t_reg_idx'(i), 17'h0FFFF);
        send_request(CMD_APPLY, 1, 0, 0, 0);
        send_request(CMD_SAMPLE, 1, 16'sh8000, 16'sh8000, 16'sh8000);
        send_request(CMD_SAMPLE, 1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        drain();
        for (int i = 0; i < 3; i++) write_reg(t_reg_idx'(i), 17'h10000);
        for (int i = 3; i < 6; i++) write_reg(t_reg_idx'(i), 17'h00000);
        send_request(CMD_APPLY, 0, 0, 0, 0);
        send_request(CMD_SAMPLE, 1, 16'sh7FFF, 16'sh0, 16'sh8000);
        drain();

        // random phases with new presets between them
        stall_on = 1;
        for (int ph = 0; ph < 8; ph++) begin
            random_presets(ph % 3 == 0);
            send_request(CMD_APPLY, 1'($urandom_range(0, 1)),
                         16'($urandom), 16'($urandom), 16'($urandom));
            for (int k = 0; k < 105; k++) begin
                case ($urandom_range(0, 19))
                    0: calib_sequence($urandom_range(0, 12));
                    1: send_request(t_cmd'($urandom_range(1, 3)), 1'($urandom_range(0, 1)),
                                    16'($urandom), 16'($urandom), 16'($urandom));
                    2: random_sample(0);
                    default: random_sample(1);
                endcase
            end
            if (ph == 4) stall_on = 0;
            if (ph == 5) stall_on = 1;
            drain();   // sender holds until all results are back
        end
        stim_done = 1;
        drain();

        $display("covered %0d requests, %0d with a sample taken, over 8 preset phases",
                 board.n_checked, board.n_used);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/mic_pkg.sv
hw/rtl/mic_if.sv
hw/rtl/mic_div.sv
hw/rtl/magnetometer_iron_calibration_unit.sv
hw/rtl/mic_chk.sv
test/magnetometer_iron_calibration_unit_tb.sv
